// ===== rtl/block_ac_rms_meter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// AC RMS meter assertion macros
// Shared concurrent assertion forms for the meter's RTL modules.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AC_RMS_METER_UNIT_MACROS_SVH
`define BLOCK_AC_RMS_METER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BACRMS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bacrms assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BACRMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bacrms assertion failed");

`endif

// ===== rtl/bacrms_pkg.sv =====
// ----------------------------------------------------------------------------
// AC RMS meter package
// Widths, step counts, sequencer states and the accumulator control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bacrms_pkg;

    localparam int MAX_BLOCK_SAMPLES = 2048;
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W    = 28;
    localparam int SQ_W     = 42;
    localparam int RMS_W    = 16;

    // width of the shared compare/subtract unit
    localparam int CSW      = RMS_W + 3;
    localparam int PROD_W   = 44;
    localparam int STEP_W   = 6;

    localparam int MEAN_DIV_STEPS = SUM_W - 1;
    localparam int MS_DIV_STEPS   = SQ_W;
    localparam int ROOT_STEPS     = RMS_W;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_LOAD    = 8'b0000_0010,
        ST_DIV_MN  = 8'b0000_0100,
        ST_MUL     = 8'b0000_1000,
        ST_SUB     = 8'b0001_0000,
        ST_DIV_MS  = 8'b0010_0000,
        ST_ROOT    = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic has;
        logic clear;
    } acc_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bacrms_cmpsub.sv =====
// ----------------------------------------------------------------------------
// AC RMS meter compare/subtract unit
// Trial subtraction shared by the restoring divider and the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module bacrms_cmpsub (
    input  wire logic [bacrms_pkg::CSW-1:0] op_a,
    input  wire logic [bacrms_pkg::CSW-1:0] op_b,
    output logic                            ge,
    output logic [bacrms_pkg::CSW-1:0]      diff
);

    logic [bacrms_pkg::CSW:0] wide_diff;

    assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
    // no borrow out means op_a >= op_b
    assign ge        = ~wide_diff[bacrms_pkg::CSW];
    assign diff      = wide_diff[bacrms_pkg::CSW-1:0];

endmodule

`default_nettype wire

// ===== rtl/bacrms_accum.sv =====
// ----------------------------------------------------------------------------
// AC RMS meter accumulators
// Running sum, sum of squares, sample count and drop flag of one block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_ac_rms_meter_unit_macros.svh"

module bacrms_accum (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire bacrms_pkg::acc_ctrl_t                 ctrl,
    input  wire logic signed [bacrms_pkg::SAMPLE_W-1:0] sample,
    output logic signed [bacrms_pkg::SUM_W-1:0]        sum,
    output logic [bacrms_pkg::SQ_W-1:0]                sq,
    output logic [bacrms_pkg::CNT_W-1:0]               cnt,
    output logic                                       dropped
);

    logic signed [bacrms_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [bacrms_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic [bacrms_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                                drop_reg, drop_next;
    logic signed [2*bacrms_pkg::SAMPLE_W-1:0] square;
    logic                                full;

    assign square = (2 * bacrms_pkg::SAMPLE_W)'(sample) * (2 * bacrms_pkg::SAMPLE_W)'(sample);
    assign full   = (cnt_reg == bacrms_pkg::CNT_W'(bacrms_pkg::MAX_BLOCK_SAMPLES));

    always_comb begin
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        priority if (ctrl.clear) begin
            sum_next  = '0;
            sq_next   = '0;
            cnt_next  = '0;
            drop_next = 1'b0;
        end else if (ctrl.load && ctrl.has) begin
            if (full) begin
                // block is full: drop the sample and remember it
                drop_next = 1'b1;
            end else begin
                sum_next = sum_reg + bacrms_pkg::SUM_W'(sample);
                sq_next  = sq_reg + bacrms_pkg::SQ_W'($unsigned(square));
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

    assign sum     = sum_reg;
    assign sq      = sq_reg;
    assign cnt     = cnt_reg;
    assign dropped = drop_reg;

    `BACRMS_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= bacrms_pkg::CNT_W'(bacrms_pkg::MAX_BLOCK_SAMPLES))
    `BACRMS_ASSERT_NEXT(a_drop_when_full, aclk, aresetn, !ctrl.clear && ctrl.load && ctrl.has && full, drop_reg)
    `BACRMS_ASSERT_NEXT(a_clear_empties, aclk, aresetn, ctrl.clear, cnt_reg == '0 && sum_reg == '0 && !drop_reg)

endmodule

`default_nettype wire

// ===== rtl/block_ac_rms_meter_unit.sv =====
// ----------------------------------------------------------------------------
// AC RMS meter
// Mean-removed RMS of a block of signed 16-bit samples, integer exact.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_sample, s_has_sample, s_last
//   m_       out  m_valid/m_ready    m_rms, m_overflowed
//
// A sample without last is taken while idle; the block is ready again at once.
// An item with last starts the end-of-block sequence: 27 divide steps for the
// mean, one multiply, one subtract, 42 divide steps and 16 root steps; the
// divide and root steps share one compare/subtract unit.
// An empty block skips the arithmetic and goes from load straight to finish.
// A result waiting in the output register stalls only the next end-of-block.
// Reset (aresetn low, synchronous) clears accumulators, sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_ac_rms_meter_unit_macros.svh"

module block_ac_rms_meter_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [bacrms_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                                  s_has_sample,
    input  wire logic                                  s_last,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [bacrms_pkg::RMS_W-1:0]               m_rms,
    output logic                                       m_overflowed
);

    bacrms_pkg::state_t state_reg, state_next;

    bacrms_pkg::acc_ctrl_t               acc_ctrl;
    logic signed [bacrms_pkg::SUM_W-1:0] acc_sum;
    logic [bacrms_pkg::SQ_W-1:0]         acc_sq;
    logic [bacrms_pkg::CNT_W-1:0]        acc_cnt;
    logic                                acc_drop;

    logic [bacrms_pkg::SQ_W-1:0]   wrk_reg, wrk_next;
    logic [bacrms_pkg::CSW-1:0]    rem_reg, rem_next;
    logic [bacrms_pkg::RMS_W-1:0]  root_reg, root_next;
    logic [bacrms_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [bacrms_pkg::STEP_W-1:0] step_reg, step_next;

    logic                          out_valid_reg, out_valid_next;
    logic [bacrms_pkg::RMS_W-1:0]  out_rms_reg, out_rms_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic [bacrms_pkg::CSW-1:0]    cs_a, cs_b, cs_diff;
    logic                          cs_ge;

    logic signed [bacrms_pkg::SUM_W-1:0] sum_neg;
    logic [bacrms_pkg::SUM_W-2:0]        sum_mag;
    logic [bacrms_pkg::SUM_W-1:0]        mul_b;
    logic                                accept;
    logic                                out_free;
    logic                                last_step;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign last_step = (step_reg == bacrms_pkg::STEP_W'(1));

    assign sum_neg = -acc_sum;
    assign sum_mag = acc_sum[bacrms_pkg::SUM_W-1] ? sum_neg[bacrms_pkg::SUM_W-2:0]
                                                  : acc_sum[bacrms_pkg::SUM_W-2:0];
    // |sum| + |remainder|: magnitude of 2*sum - n*mean
    assign mul_b   = {1'b0, sum_mag} + bacrms_pkg::SUM_W'(rem_reg[bacrms_pkg::CNT_W-2:0]);

    assign acc_ctrl.load  = accept;
    assign acc_ctrl.has   = s_has_sample;
    assign acc_ctrl.clear = (state_reg == bacrms_pkg::ST_FINISH) && out_free;

    bacrms_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (acc_ctrl),
        .sample  (s_sample),
        .sum     (acc_sum),
        .sq      (acc_sq),
        .cnt     (acc_cnt),
        .dropped (acc_drop)
    );

    // operand select for the shared unit
    always_comb begin
        cs_a = '0;
        cs_b = '0;
        unique case (state_reg)
            bacrms_pkg::ST_DIV_MN, bacrms_pkg::ST_DIV_MS: begin
                cs_a = bacrms_pkg::CSW'({rem_reg[bacrms_pkg::CNT_W-1:0],
                                          wrk_reg[bacrms_pkg::SQ_W-1]});
                cs_b = bacrms_pkg::CSW'(acc_cnt);
            end
            bacrms_pkg::ST_ROOT: begin
                cs_a = {rem_reg[bacrms_pkg::CSW-3:0], wrk_reg[31:30]};
                cs_b = bacrms_pkg::CSW'({root_reg, 2'b01});
            end
            default: begin
                cs_a = '0;
                cs_b = '0;
            end
        endcase
    end

    bacrms_cmpsub u_cmpsub (
        .op_a (cs_a),
        .op_b (cs_b),
        .ge   (cs_ge),
        .diff (cs_diff)
    );

    always_comb begin
        state_next     = state_reg;
        wrk_next       = wrk_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        prod_next      = prod_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_rms_next   = out_rms_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bacrms_pkg::ST_IDLE: begin
                if (accept && s_last) begin
                    state_next = bacrms_pkg::ST_LOAD;
                end
            end
            bacrms_pkg::ST_LOAD: begin
                rem_next  = '0;
                root_next = '0;
                if (acc_cnt == '0) begin
                    // empty block: result is zero
                    state_next = bacrms_pkg::ST_FINISH;
                end else begin
                    wrk_next   = {sum_mag, (bacrms_pkg::SQ_W - bacrms_pkg::SUM_W + 1)'(0)};
                    step_next  = bacrms_pkg::STEP_W'(bacrms_pkg::MEAN_DIV_STEPS);
                    state_next = bacrms_pkg::ST_DIV_MN;
                end
            end
            bacrms_pkg::ST_DIV_MN: begin
                rem_next  = cs_ge ? cs_diff : cs_a;
                wrk_next  = {wrk_reg[bacrms_pkg::SQ_W-2:0], cs_ge};
                step_next = step_reg - 1'b1;
                if (last_step) begin
                    state_next = bacrms_pkg::ST_MUL;
                end
            end
            bacrms_pkg::ST_MUL: begin
                // |mean| * (|sum| + |rem|)
                prod_next  = bacrms_pkg::PROD_W'(wrk_reg[15:0]) * bacrms_pkg::PROD_W'(mul_b);
                state_next = bacrms_pkg::ST_SUB;
            end
            bacrms_pkg::ST_SUB: begin
                wrk_next   = acc_sq - prod_reg[bacrms_pkg::SQ_W-1:0];
                rem_next   = '0;
                step_next  = bacrms_pkg::STEP_W'(bacrms_pkg::MS_DIV_STEPS);
                state_next = bacrms_pkg::ST_DIV_MS;
            end
            bacrms_pkg::ST_DIV_MS: begin
                rem_next  = cs_ge ? cs_diff : cs_a;
                wrk_next  = {wrk_reg[bacrms_pkg::SQ_W-2:0], cs_ge};
                step_next = step_reg - 1'b1;
                if (last_step) begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = bacrms_pkg::STEP_W'(bacrms_pkg::ROOT_STEPS);
                    state_next = bacrms_pkg::ST_ROOT;
                end
            end
            bacrms_pkg::ST_ROOT: begin
                // two radicand bits per step, one root bit out
                rem_next  = cs_ge ? cs_diff : cs_a;
                wrk_next  = {wrk_reg[bacrms_pkg::SQ_W-3:0], 2'b00};
                root_next = {root_reg[bacrms_pkg::RMS_W-2:0], cs_ge};
                step_next = step_reg - 1'b1;
                if (last_step) begin
                    state_next = bacrms_pkg::ST_FINISH;
                end
            end
            bacrms_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_rms_next   = root_reg;
                    out_ovf_next   = acc_drop;
                    state_next     = bacrms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bacrms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bacrms_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wrk_reg     <= wrk_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        prod_reg    <= prod_next;
        out_rms_reg <= out_rms_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign s_ready      = (state_reg == bacrms_pkg::ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_rms        = out_rms_reg;
    assign m_overflowed = out_ovf_reg;

    `BACRMS_ASSERT_NEXT(a_finish_delivers, aclk, aresetn, state_reg == bacrms_pkg::ST_FINISH && out_free, m_valid && state_reg == bacrms_pkg::ST_IDLE)
    `BACRMS_ASSERT_NEXT(a_empty_skips, aclk, aresetn, state_reg == bacrms_pkg::ST_LOAD && acc_cnt == '0, state_reg == bacrms_pkg::ST_FINISH && root_reg == '0)
    `BACRMS_ASSERT_NOW(a_step_live, aclk, aresetn, state_reg == bacrms_pkg::ST_ROOT || state_reg == bacrms_pkg::ST_DIV_MS || state_reg == bacrms_pkg::ST_DIV_MN, step_reg != '0)
    `BACRMS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rms) && $stable(m_overflowed))

endmodule

`default_nettype wire
